// ----- hw/rtl/sau_pkg.sv -----
// Shared constants, types and the elaboration-time interpolation table for the softplus unit.
`timescale 1ns / 1ps

package sau_pkg;

   // Fixed-point format and table size.
   localparam int FRAC_BITS     = 10;
   localparam int TABLE_ENTRIES = 256;

   // The table spans |x| in [0, 16), that is [0, 2^SPAN_SHIFT) in input units.
   localparam int SPAN_SHIFT = FRAC_BITS + 4;

   // Field and datapath widths.
   localparam int DATA_W = 16;
   localparam int A_W    = DATA_W + 1;
   localparam int E_W    = FRAC_BITS + 1;
   localparam int PAIR_W = 4 * E_W;
   localparam int IDX_W  = $clog2(TABLE_ENTRIES);
   localparam int PROD_A = A_W + $clog2(TABLE_ENTRIES + 1);
   localparam int PROD_W = (PROD_A > SPAN_SHIFT + IDX_W) ? PROD_A : SPAN_SHIFT + IDX_W;
   localparam int IP_W   = E_W + SPAN_SHIFT + 2;
   localparam int PP_W   = DATA_W + E_W + 1;

   // Mode register codes.
   localparam logic MODE_FORWARD  = 1'b0;
   localparam logic MODE_BACKWARD = 1'b1;

   typedef enum logic {
      ST_FILL,
      ST_RUN
   } sau_state_type;

   // One table word holds both nodes of an interval for both functions:
   // {corr[i], corr[i+1], sig[i], sig[i+1]}.
   typedef logic [PAIR_W-1:0] pair_rom_type [TABLE_ENTRIES];

   localparam logic [63:0] Q30_ONE = 64'd1 << 30;

   // The functions below are evaluated at elaboration only, to build PAIR_ROM.

   // Unsigned 64-bit quotient by restoring long division.
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      rem = 65'd0;
      quo = 64'd0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // exp(u) for u in [0, 1], Q30.
   function automatic logic [63:0] exp_pos_q30(input logic [63:0] u);
      logic [63:0] sum;
      logic [63:0] term;
      sum  = Q30_ONE;
      term = Q30_ONE;
      for (int n = 1; n < 24; n++) begin
         term = udiv64((term * u) >> 30, 64'(n));
         sum  = sum + term;
      end
      return sum;
   endfunction

   // exp(-t) for t in [0, 16], Q30.
   function automatic logic [63:0] exp_neg_q30(input logic [63:0] t);
      logic [63:0] inv_e;
      logic [63:0] r;
      logic [63:0] k;
      inv_e = udiv64(64'd1 << 60, exp_pos_q30(Q30_ONE));
      r     = udiv64(64'd1 << 60, exp_pos_q30(t & (Q30_ONE - 64'd1)));
      k     = t >> 30;
      for (int j = 0; j < 16; j++) begin
         if (64'(j) < k) begin
            r = (r * inv_e) >> 30;
         end
      end
      return r;
   endfunction

   // log(1+z) for z in [0, 1], Q30, as 2*atanh(z/(2+z)).
   function automatic logic [63:0] log1p_q30(input logic [63:0] z);
      logic [63:0] w;
      logic [63:0] w2;
      logic [63:0] p;
      logic [63:0] sum;
      w   = udiv64(z << 30, (64'd2 * Q30_ONE) + z);
      w2  = (w * w) >> 30;
      p   = w;
      sum = 64'd0;
      for (int k = 0; k < 24; k++) begin
         sum = sum + udiv64(p, 64'(2 * k + 1));
         p   = (p * w2) >> 30;
      end
      return 64'd2 * sum;
   endfunction

   // Round a Q30 value to FRAC_BITS fraction bits, ties up.
   function automatic logic [E_W-1:0] q30_to_frac(input logic [63:0] v);
      logic [63:0] r;
      r = (v + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
      return r[E_W-1:0];
   endfunction

   function automatic pair_rom_type build_pair_rom();
      pair_rom_type rom;
      logic [E_W-1:0] corr_tab [TABLE_ENTRIES+1];
      logic [E_W-1:0] sig_tab  [TABLE_ENTRIES+1];
      logic [63:0] t;
      logic [63:0] e;
      for (int i = 0; i <= TABLE_ENTRIES; i++) begin
         t           = (64'(i) << 34) / 64'(TABLE_ENTRIES);
         e           = exp_neg_q30(t);
         corr_tab[i] = q30_to_frac(log1p_q30(e));
         sig_tab[i]  = q30_to_frac(udiv64(64'd1 << 60, Q30_ONE + e));
      end
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         rom[i] = {corr_tab[i], corr_tab[i+1], sig_tab[i], sig_tab[i+1]};
      end
      return rom;
   endfunction

   localparam pair_rom_type PAIR_ROM = build_pair_rom();

endpackage

// ----- hw/rtl/sau_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module sau_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/softplus_activation_unit.sv -----
// Top level of the softplus activation unit with its sigmoid gradient mode.
`timescale 1ns / 1ps

// Elementwise softplus unit for signed Q5.10 data. With mode 0 each request transaction
// carrying x returns max(x,0) + log1p(exp(-|x|)); with mode 1 it returns dy * sigmoid(x).
// Both functions are linearly interpolated from a table over |x| in [0,16) and results
// saturate to 16 bits. The unit accepts one transaction per clock cycle sustained while
// responses are not stalled, and each result passes through the table RAM read, the
// interpolation multiply, the gradient multiply and the output register. A stalled
// response holds only the stages behind it, so empty stages still take new requests.
// After reset the unit copies the interpolation table into its RAM, one word a cycle,
// and holds req_stall high meanwhile. The mode register is written through
// csr_write_enable at any time, but should only change while no transactions are in flight.
module softplus_activation_unit
   import sau_pkg::*;
(
   input  logic              clock,
   input  logic              reset,

   input  logic              csr_write_enable,
   input  logic              csr_write_data,

   input  logic              req_valid,
   output logic              req_stall,
   input  logic [DATA_W-1:0] req_x,
   input  logic [DATA_W-1:0] req_dy,

   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [DATA_W-1:0] rsp_result
);

   localparam logic [E_W-1:0]      ONE_FIX = E_W'(2 ** FRAC_BITS);
   localparam logic signed [IP_W:0] IP_HALF = (IP_W+1)'(2 ** (SPAN_SHIFT - 1));
   localparam logic signed [PP_W:0] PP_HALF = (PP_W+1)'(2 ** (FRAC_BITS - 1));
   localparam logic signed [PP_W:0] SAT_HI  = (PP_W+1)'(32767);
   localparam logic signed [PP_W:0] SAT_LO  = (PP_W+1)'(-32768);

   // Mode register.
   logic mode_ff;
   logic mode_in;

   // Table fill sequencer.
   sau_state_type    state_ff;
   sau_state_type    state_in;
   logic [IDX_W-1:0] fill_cnt_ff;
   logic [IDX_W-1:0] fill_cnt_in;
   logic             fill_last;
   logic             fill_wr_en;
   logic             run;

   // Handshake chain.
   logic out_ready;
   logic p3_ready;
   logic p2_ready;
   logic p1_ready;
   logic req_accept;

   // Accept stage.
   logic [A_W-1:0]    a_abs;
   logic              span0;
   logic [PROD_W-1:0] prod0;
   logic [IDX_W-1:0]  ram_rd_addr;
   logic [PAIR_W-1:0] ram_rd_data;

   // Stage 1: table word available.
   logic                  p1_valid_ff, p1_valid_in;
   logic [DATA_W-1:0]     p1_x_ff, p1_x_in;
   logic [DATA_W-1:0]     p1_dy_ff, p1_dy_in;
   logic [SPAN_SHIFT-1:0] p1_rem_ff, p1_rem_in;
   logic                  p1_span_ff, p1_span_in;
   logic                  p1_mode_ff, p1_mode_in;
   logic [E_W-1:0]        lo1;
   logic [E_W-1:0]        hi1;
   logic signed [E_W:0]   d1;
   logic signed [IP_W-1:0] ip1;

   // Stage 2: interpolation product registered.
   logic                   p2_valid_ff, p2_valid_in;
   logic [DATA_W-1:0]      p2_x_ff, p2_x_in;
   logic [DATA_W-1:0]      p2_dy_ff, p2_dy_in;
   logic                   p2_span_ff, p2_span_in;
   logic                   p2_mode_ff, p2_mode_in;
   logic [E_W-1:0]         p2_lo_ff, p2_lo_in;
   logic signed [IP_W-1:0] p2_ip_ff, p2_ip_in;
   logic signed [IP_W:0]   rnd2;
   logic signed [IP_W:0]   q2;
   logic signed [E_W+1:0]  vsum2;
   logic [E_W-1:0]         v2;
   logic [E_W-1:0]         corr2;
   logic [E_W-1:0]         sig_abs2;
   logic [E_W-1:0]         sig2;
   logic [DATA_W:0]        fsum2;
   logic [DATA_W-1:0]      fwd2;
   logic signed [PP_W-1:0] pp2;

   // Stage 3: forward result and gradient product registered.
   logic                   p3_valid_ff, p3_valid_in;
   logic                   p3_mode_ff, p3_mode_in;
   logic [DATA_W-1:0]      p3_fwd_ff, p3_fwd_in;
   logic signed [PP_W-1:0] p3_pp_ff, p3_pp_in;
   logic signed [PP_W:0]   rnd3;
   logic signed [PP_W:0]   q3;
   logic [DATA_W-1:0]      bwd3;

   // Output register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_result_ff, rsp_result_in;

   // ------------------------------------------------------------------
   // Mode register.
   // ------------------------------------------------------------------
   always_comb begin
      mode_in = csr_write_enable ? csr_write_data : mode_ff;
   end

   // ------------------------------------------------------------------
   // Table fill sequencer. The RAM is loaded from the constant table after
   // reset; requests are held off until the last word is written.
   // ------------------------------------------------------------------
   assign fill_last = (fill_cnt_ff == IDX_W'(TABLE_ENTRIES - 1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_FILL: begin
            if (fill_last) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            state_in = ST_RUN;
         end
         default: begin
            state_in = ST_FILL;
         end
      endcase
   end

   always_comb begin
      fill_wr_en = 1'b0;
      run        = 1'b0;
      case (state_ff)
         ST_FILL: begin
            fill_wr_en = 1'b1;
         end
         ST_RUN: begin
            run = 1'b1;
         end
         default: begin
            fill_wr_en = 1'b0;
            run        = 1'b0;
         end
      endcase
   end

   always_comb begin
      fill_cnt_in = fill_wr_en ? fill_cnt_ff + IDX_W'(1) : fill_cnt_ff;
   end

   // ------------------------------------------------------------------
   // Handshake. Each stage moves when it is empty or the stage after it
   // moves, so bubbles are squeezed out behind a stalled response.
   // ------------------------------------------------------------------
   assign out_ready  = !rsp_valid_ff || !rsp_stall;
   assign p3_ready   = !p3_valid_ff || out_ready;
   assign p2_ready   = !p2_valid_ff || p3_ready;
   assign p1_ready   = !p1_valid_ff || p2_ready;
   assign req_stall  = !run || !p1_ready;
   assign req_accept = req_valid && !req_stall;

   // ------------------------------------------------------------------
   // Accept stage: |x|, table index and interpolation fraction.
   // ------------------------------------------------------------------
   always_comb begin
      if (req_x[DATA_W-1]) begin
         a_abs = A_W'(0) - {req_x[DATA_W-1], req_x};
      end else begin
         a_abs = {1'b0, req_x};
      end
      span0       = ({15'd0, a_abs} < (32'd1 << SPAN_SHIFT));
      prod0       = PROD_W'(a_abs) * PROD_W'(TABLE_ENTRIES);
      ram_rd_addr = prod0[SPAN_SHIFT +: IDX_W];
   end

   sau_ram #(
      .WIDTH (PAIR_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_table_ram (
      .clock   (clock),
      .wr_en   (fill_wr_en),
      .wr_addr (fill_cnt_ff),
      .wr_data (PAIR_ROM[fill_cnt_ff]),
      .rd_en   (p1_ready),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      p1_valid_in = p1_valid_ff;
      p1_x_in     = p1_x_ff;
      p1_dy_in    = p1_dy_ff;
      p1_rem_in   = p1_rem_ff;
      p1_span_in  = p1_span_ff;
      p1_mode_in  = p1_mode_ff;
      if (p1_ready) begin
         p1_valid_in = req_accept;
         p1_x_in     = req_x;
         p1_dy_in    = req_dy;
         p1_rem_in   = prod0[SPAN_SHIFT-1:0];
         p1_span_in  = span0;
         p1_mode_in  = mode_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: pick the nodes of the selected function and multiply their
   // difference by the fraction.
   // ------------------------------------------------------------------
   always_comb begin
      if (p1_mode_ff == MODE_BACKWARD) begin
         lo1 = ram_rd_data[2*E_W-1 -: E_W];
         hi1 = ram_rd_data[E_W-1:0];
      end else begin
         lo1 = ram_rd_data[4*E_W-1 -: E_W];
         hi1 = ram_rd_data[3*E_W-1 -: E_W];
      end
      d1  = $signed({1'b0, hi1}) - $signed({1'b0, lo1});
      ip1 = IP_W'(d1) * IP_W'($signed({1'b0, p1_rem_ff}));
   end

   always_comb begin
      p2_valid_in = p2_valid_ff;
      p2_x_in     = p2_x_ff;
      p2_dy_in    = p2_dy_ff;
      p2_span_in  = p2_span_ff;
      p2_mode_in  = p2_mode_ff;
      p2_lo_in    = p2_lo_ff;
      p2_ip_in    = p2_ip_ff;
      if (p2_ready) begin
         p2_valid_in = p1_valid_ff;
         p2_x_in     = p1_x_ff;
         p2_dy_in    = p1_dy_ff;
         p2_span_in  = p1_span_ff;
         p2_mode_in  = p1_mode_ff;
         p2_lo_in    = lo1;
         p2_ip_in    = ip1;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: round the interpolation, apply the out-of-span values and the
   // mirror for negative x, then form the forward sum and gradient product.
   // ------------------------------------------------------------------
   always_comb begin
      rnd2  = (IP_W+1)'(p2_ip_ff) + IP_HALF;
      q2    = rnd2 >>> SPAN_SHIFT;
      vsum2 = $signed({2'b00, p2_lo_ff}) + (E_W+2)'(q2);
      v2    = vsum2[E_W-1:0];

      corr2    = p2_span_ff ? v2 : E_W'(0);
      sig_abs2 = p2_span_ff ? v2 : ONE_FIX;
      sig2     = p2_x_ff[DATA_W-1] ? (ONE_FIX - sig_abs2) : sig_abs2;

      // Softplus: the positive part of x plus the correction, capped at the top.
      if (p2_x_ff[DATA_W-1]) begin
         fsum2 = (DATA_W+1)'(corr2);
      end else begin
         fsum2 = {1'b0, p2_x_ff} + (DATA_W+1)'(corr2);
      end
      fwd2 = fsum2[DATA_W] || fsum2[DATA_W-1] ? 16'h7FFF : fsum2[DATA_W-1:0];

      pp2 = PP_W'($signed(p2_dy_ff)) * PP_W'($signed({1'b0, sig2}));
   end

   always_comb begin
      p3_valid_in = p3_valid_ff;
      p3_mode_in  = p3_mode_ff;
      p3_fwd_in   = p3_fwd_ff;
      p3_pp_in    = p3_pp_ff;
      if (p3_ready) begin
         p3_valid_in = p2_valid_ff;
         p3_mode_in  = p2_mode_ff;
         p3_fwd_in   = fwd2;
         p3_pp_in    = pp2;
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: round and saturate the gradient, select the result.
   // ------------------------------------------------------------------
   always_comb begin
      rnd3 = (PP_W+1)'(p3_pp_ff) + PP_HALF;
      q3   = rnd3 >>> FRAC_BITS;
      if (q3 > SAT_HI) begin
         bwd3 = 16'h7FFF;
      end else if (q3 < SAT_LO) begin
         bwd3 = 16'h8000;
      end else begin
         bwd3 = q3[DATA_W-1:0];
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_result_in = rsp_result_ff;
      if (out_ready) begin
         rsp_valid_in  = p3_valid_ff;
         rsp_result_in = (p3_mode_ff == MODE_BACKWARD) ? bwd3 : p3_fwd_ff;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;

   // ------------------------------------------------------------------
   // Registers. Control state is reset; payload is not.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_FORWARD;
         state_ff     <= ST_FILL;
         fill_cnt_ff  <= '0;
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         p3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         state_ff     <= state_in;
         fill_cnt_ff  <= fill_cnt_in;
         p1_valid_ff  <= p1_valid_in;
         p2_valid_ff  <= p2_valid_in;
         p3_valid_ff  <= p3_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p1_x_ff       <= p1_x_in;
      p1_dy_ff      <= p1_dy_in;
      p1_rem_ff     <= p1_rem_in;
      p1_span_ff    <= p1_span_in;
      p1_mode_ff    <= p1_mode_in;
      p2_x_ff       <= p2_x_in;
      p2_dy_ff      <= p2_dy_in;
      p2_span_ff    <= p2_span_in;
      p2_mode_ff    <= p2_mode_in;
      p2_lo_ff      <= p2_lo_in;
      p2_ip_ff      <= p2_ip_in;
      p3_mode_ff    <= p3_mode_in;
      p3_fwd_ff     <= p3_fwd_in;
      p3_pp_ff      <= p3_pp_in;
      rsp_result_ff <= rsp_result_in;
   end

endmodule

// ----- tb/tb_softplus_activation_unit.sv -----
// Self-checking testbench for the softplus activation unit in its forward and gradient modes.
`timescale 1ns / 1ps

// The testbench drives request transactions into the unit, predicts each result with its own
// copy of the interpolation tables and of the mode register, and compares every response
// transaction against the oldest outstanding prediction. Inputs change on the falling clock
// edge. Handshakes and register writes are sampled on the rising edge, which is when the unit
// itself sees them.
module tb_softplus_activation_unit;
   import sau_pkg::*;

   // Generous bound on the whole run.
   localparam int CYCLE_LIMIT     = 400000;
   localparam int ITEMS_PER_PHASE = 210;
   localparam int REPORT_LIMIT    = 10;

   // One predicted result, together with the request that produced it for reporting.
   typedef struct {
      logic signed [DATA_W-1:0] x;
      logic signed [DATA_W-1:0] dy;
      logic                     mode;
      logic [DATA_W-1:0]        result;
   } softplus_expectation_type;

   // Predicts softplus or the sigmoid-weighted gradient for every accepted request and
   // checks the response stream in order.
   class softplus_scoreboard;
      int                       corr_nodes[TABLE_ENTRIES+1];
      int                       sig_nodes[TABLE_ENTRIES+1];
      logic                     mode;
      softplus_expectation_type awaited_results[$];
      int                       failures;

      function new();
         mode     = MODE_FORWARD;
         failures = 0;
         build_nodes();
      endfunction

      // exp(u) for u in [0, 1], Q30, by its power series.
      function bit [63:0] exp_unit_q30(bit [63:0] u);
         bit [63:0] total;
         bit [63:0] term;
         total = 64'd1 << 30;
         term  = 64'd1 << 30;
         for (int n = 1; n < 24; n++) begin
            term  = ((term * u) >> 30) / 64'(n);
            total = total + term;
         end
         return total;
      endfunction

      // Q30 to FRAC_BITS fraction bits, ties rounded up.
      function int round_q30(bit [63:0] v);
         return int'((v + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
      endfunction

      // Node i sits at 16*i/TABLE_ENTRIES. The correction term is log1p(exp(-t)), taken as
      // 2*atanh(z/(2+z)) with z = exp(-t). The sigmoid node is 1/(1+exp(-t)).
      function void build_nodes();
         bit [63:0] one;
         bit [63:0] inv_e;
         bit [63:0] t;
         bit [63:0] e;
         bit [63:0] w;
         bit [63:0] w2;
         bit [63:0] p;
         bit [63:0] acc;
         one   = 64'd1 << 30;
         inv_e = (64'd1 << 60) / exp_unit_q30(one);
         for (int i = 0; i <= TABLE_ENTRIES; i++) begin
            t = (64'(i) << 34) / 64'(TABLE_ENTRIES);
            e = (64'd1 << 60) / exp_unit_q30(t & (one - 64'd1));
            for (int k = 0; k < int'(t >> 30); k++) begin
               e = (e * inv_e) >> 30;
            end
            w   = (e << 30) / ((64'd2 * one) + e);
            w2  = (w * w) >> 30;
            p   = w;
            acc = 64'd0;
            for (int k = 0; k < 24; k++) begin
               acc = acc + p / 64'(2 * k + 1);
               p   = (p * w2) >> 30;
            end
            corr_nodes[i] = round_q30(64'd2 * acc);
            sig_nodes[i]  = round_q30((64'd1 << 60) / (one + e));
         end
      endfunction

      // Linear interpolation between two nodes, rounded to nearest with ties upward.
      function longint interpolate(bit pick_sig, longint a);
         longint prod;
         longint idx;
         longint rem;
         longint lo;
         longint hi;
         prod = a * TABLE_ENTRIES;
         idx  = prod >>> SPAN_SHIFT;
         rem  = prod & ((longint'(1) << SPAN_SHIFT) - 1);
         if (idx >= TABLE_ENTRIES) begin
            idx = TABLE_ENTRIES - 1;
         end
         lo = longint'(pick_sig ? sig_nodes[idx] : corr_nodes[idx]);
         hi = longint'(pick_sig ? sig_nodes[idx+1] : corr_nodes[idx+1]);
         return lo + (((hi - lo) * rem + (longint'(1) << (SPAN_SHIFT - 1))) >>> SPAN_SHIFT);
      endfunction

      function logic [DATA_W-1:0] softplus_predict(logic signed [DATA_W-1:0] x,
                                                   logic signed [DATA_W-1:0] dy);
         longint a;
         longint c;
         longint s;
         longint res;
         a = (x < 0) ? -longint'(x) : longint'(x);
         if (mode == MODE_FORWARD) begin
            c = 0;
            if (a < (longint'(1) << SPAN_SHIFT)) begin
               c = interpolate(1'b0, a);
            end
            res = ((x > 0) ? longint'(x) : longint'(0)) + c;
         end else begin
            s = longint'(1) << FRAC_BITS;
            if (a < (longint'(1) << SPAN_SHIFT)) begin
               s = interpolate(1'b1, a);
            end
            if (x < 0) begin
               s = (longint'(1) << FRAC_BITS) - s;
            end
            res = (longint'(dy) * s + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
         end
         if (res > 32767) begin
            res = 32767;
         end else if (res < -32768) begin
            res = -32768;
         end
         return res[DATA_W-1:0];
      endfunction

      function void set_mode(logic m);
         mode = m;
      endfunction

      function void note_request(logic signed [DATA_W-1:0] x, logic signed [DATA_W-1:0] dy);
         softplus_expectation_type entry;
         entry.x      = x;
         entry.dy     = dy;
         entry.mode   = mode;
         entry.result = softplus_predict(x, dy);
         awaited_results.push_back(entry);
      endfunction

      function void check_result(logic [DATA_W-1:0] got);
         softplus_expectation_type want;
         if (awaited_results.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT) begin
               $display("unexpected result %0d with no request outstanding", $signed(got));
            end
            return;
         end
         want = awaited_results.pop_front();
         if (got !== want.result) begin
            failures++;
            if (failures <= REPORT_LIMIT) begin
               $display("result mismatch: mode %0d x %0d dy %0d expected %0d actual %0d",
                        want.mode, want.x, want.dy, $signed(want.result), $signed(got));
            end
         end
      endfunction

      function int pending();
         return awaited_results.size();
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              csr_write_enable;
   logic              csr_write_data;
   logic              req_valid;
   logic              req_stall;
   logic [DATA_W-1:0] req_x;
   logic [DATA_W-1:0] req_dy;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [DATA_W-1:0] rsp_result;

   // Idling profile of the current phase, in percent of cycles. They are changed just after
   // a rising edge, so the processes that read them on the falling edge never race.
   int send_idle_pct;
   int recv_stall_pct;
   // Remaining cycles of a forced receiver hold-off. Set by the stimulus after a rising edge
   // and counted down by the receiver on falling edges.
   int hold_left;

   // Idling profiles: none, sender idle, receiver stalling, both.
   int send_idle_pcts[4]  = '{0, 66, 0, 23};
   int recv_stall_pcts[4] = '{0, 0, 66, 23};

   softplus_scoreboard softplus_sb;

   softplus_activation_unit dut (
      .clock           (clock),
      .reset           (reset),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_x           (req_x),
      .req_dy          (req_dy),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result      (rsp_result)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Monitor. A register write is recorded before a request of the same edge would be,
   // although the stimulus never issues both together.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_write_enable) begin
            softplus_sb.set_mode(csr_write_data);
         end
         if (req_valid && !req_stall) begin
            softplus_sb.note_request(req_x, req_dy);
         end
         if (rsp_valid && !rsp_stall) begin
            softplus_sb.check_result(rsp_result);
         end
      end
   end

   // Receiver. It stalls at the phase's rate, or continuously while a hold-off is running.
   initial begin : receiver
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   initial begin : watchdog
      int cycles_run;
      cycles_run = 0;
      while (cycles_run < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles_run++;
      end
      $display("tb_softplus_activation_unit failed");
      $finish;
   end

   // Offers one request transaction and returns on the falling edge after it was taken.
   // It is entered on a falling edge. Idle cycles before the transaction carry random
   // payload, which the unit has to ignore. Valid stays high when the next call comes
   // straight away, so back-to-back transactions are possible.
   task automatic send_item(input logic signed [DATA_W-1:0] x,
                            input logic signed [DATA_W-1:0] dy);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) begin
         gap++;
      end
      repeat (gap) begin
         req_valid <= 1'b0;
         req_x     <= DATA_W'($urandom);
         req_dy    <= DATA_W'($urandom);
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_x     <= x;
      req_dy    <= dy;
      forever begin
         @(posedge clock);
         if (!req_stall) begin
            break;
         end
      end
      @(negedge clock);
   endtask

   // Stops offering and waits, on falling edges, until every predicted result has arrived.
   // Every request produces one result, so nothing is left in flight after that.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (softplus_sb.pending() != 0) begin
         @(negedge clock);
      end
   endtask

   // Writes the mode register while the unit is idle and switches the idling profile.
   task automatic start_phase(input logic m, input int send_pct, input int stall_pct);
      req_valid        <= 1'b0;
      csr_write_enable <= 1'b1;
      csr_write_data   <= m;
      @(posedge clock);
      send_idle_pct  = send_pct;
      recv_stall_pct = stall_pct;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Directed inputs: zero, one step either side of it, the ends of the range, both sides of
   // the edge of the table span, an exact table node and a value just off one.
   logic signed [DATA_W-1:0] directed_x[12] =
      '{16'sd0, 16'sd1, -16'sd1, 16'sd32767, -16'sd32768, 16'sd16383, 16'sd16384,
        -16'sd16383, -16'sd16384, 16'sd64, -16'sd65, 16'sd5000};
   // Gradients paired with them in the gradient mode: the extremes, zero and unit steps.
   logic signed [DATA_W-1:0] directed_dy[12] =
      '{16'sd32767, -16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768,
        16'sd1, 16'sd32767, 16'sd32767, -16'sd1, 16'sd1, 16'sd0};
   logic signed [DATA_W-1:0] dy_corners[5] = '{16'sd32767, -16'sd32768, 16'sd0, 16'sd1, -16'sd1};

   initial begin : stimulus
      logic signed [DATA_W-1:0] x;
      logic signed [DATA_W-1:0] dy;
      softplus_sb      = new();
      send_idle_pct    = 0;
      recv_stall_pct   = 0;
      hold_left        = 0;
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = 1'b0;
      req_valid        = 1'b0;
      req_x            = '0;
      req_dy           = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Forward mode straight out of reset. The unit holds req_stall while it fills its
      // table, and the first transaction simply waits for that.
      foreach (directed_x[i]) begin
         send_item(directed_x[i], DATA_W'($urandom));
      end
      wait_drained();

      // Gradient mode on the same inputs, with gradients at their extremes, zero and unit steps.
      start_phase(MODE_BACKWARD, 23, 23);
      foreach (directed_x[i]) begin
         send_item(directed_x[i], directed_dy[i]);
      end

      // Random phases: each idling profile in both modes. Inputs are spread over the whole
      // range, over the table span, around table nodes and over the corner values.
      for (int prof = 0; prof < 4; prof++) begin
         for (int m = 0; m < 2; m++) begin
            wait_drained();
            start_phase((m == 1) ? MODE_BACKWARD : MODE_FORWARD,
                        send_idle_pcts[prof], recv_stall_pcts[prof]);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
               // Halfway through the phase without idling the receiver holds off for long
               // enough that the pipeline fills and the unit has to stall its requests.
               if (prof == 0 && n == ITEMS_PER_PHASE / 2) begin
                  req_valid <= 1'b0;
                  @(posedge clock);
                  hold_left = 80;
                  @(negedge clock);
               end
               case ($urandom_range(9))
                  0, 1, 2, 3: begin
                     x = DATA_W'($urandom);
                  end
                  4, 5, 6, 7: begin
                     x = DATA_W'($urandom_range(16383));
                     if ($urandom_range(1) == 1) begin
                        x = -x;
                     end
                  end
                  8: begin
                     x = DATA_W'(($urandom_range(TABLE_ENTRIES) << 6) + $urandom_range(2) - 1);
                     if ($urandom_range(1) == 1) begin
                        x = -x;
                     end
                  end
                  default: begin
                     x = directed_x[$urandom_range(11)];
                  end
               endcase
               if ($urandom_range(9) == 0) begin
                  dy = dy_corners[$urandom_range(4)];
               end else begin
                  dy = DATA_W'($urandom);
               end
               send_item(x, dy);
            end
         end
      end

      wait_drained();
      // A few more cycles to catch any stray response after the last expected one.
      repeat (12) @(posedge clock);
      if (softplus_sb.failures == 0 && softplus_sb.pending() == 0) begin
         $display("tb_softplus_activation_unit passed");
      end else begin
         $display("tb_softplus_activation_unit failed");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/sau_pkg.sv
hw/rtl/sau_ram.sv
hw/rtl/softplus_activation_unit.sv
tb/tb_softplus_activation_unit.sv
